[hw/rtl/assert_macros.svh]
// Assertion macros shared by the rational arithmetic unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Whenever cond holds, expr must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Whenever cond holds, expr must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

[hw/rtl/rau_pkg.sv]
// Shared types and codes of the rational arithmetic unit.
package rau_pkg;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_OVF  = 2'd1,
      ST_DIVZ = 2'd2
   } status_type;

   // Classified operation handed from the front part to the back part.
   typedef struct packed {
      status_type        status;
      logic signed [31:0] num;
      logic signed [31:0] den;
   } entry_type;

endpackage

[hw/rtl/rau_req_if.sv]
// Request channel of the rational arithmetic unit.
interface rau_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic signed [31:0] a_num;
   logic [30:0]        a_den;
   logic signed [31:0] b_num;
   logic [30:0]        b_den;

   modport source (output valid, func, a_num, a_den, b_num, b_den, input ready);
   modport sink (input valid, func, a_num, a_den, b_num, b_den, output ready);
endinterface

[hw/rtl/rau_rsp_if.sv]
// Response channel of the rational arithmetic unit.
interface rau_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] res_num;
   logic [30:0]        res_den;
   logic [1:0]         status;

   modport source (output valid, res_num, res_den, status, input ready);
   modport sink (input valid, res_num, res_den, status, output ready);
endinterface

[hw/rtl/rational_arithmetic_unit_top.sv]
// Rational arithmetic unit: add, subtract, multiply or divide two fractions with GCD reduction.
// Each request passes a front part that forms the three cross products on one shared
// multiplier and checks for overflow and division by zero, then waits in a two-entry
// queue for the back part. The back part reduces by a binary GCD (one shift or subtract per
// cycle) and then divides numerator and denominator by the GCD in two restoring dividers
// running side by side; error requests skip the GCD and the dividers. The back part takes
// one entry at a time, so it sets the sustained rate. A finished response waits in an output
// register while the front part already takes the next request. WIDTH sets the signed range
// that results must fit; the ports keep their full widths.
module rational_arithmetic_unit_top #(
   parameter int WIDTH = 32
) (
   input logic       clock,
   input logic       reset,
   rau_req_if.sink   req_chan,
   rau_rsp_if.source rsp_chan
);

   logic               push;
   logic               full;
   logic               pop;
   logic               empty;
   rau_pkg::entry_type push_entry;
   rau_pkg::entry_type pop_entry;

   rau_front #(.WIDTH(WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push       (push),
      .push_entry (push_entry),
      .full       (full)
   );

   rau_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .empty      (empty)
   );

   rau_back #(.WIDTH(WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (empty),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

[hw/rtl/rau_queue.sv]
// Two-entry queue between the front and back parts.
`include "assert_macros.svh"

module rau_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rau_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output rau_pkg::entry_type pop_entry,
   output logic               empty
);

   rau_pkg::entry_type mem_ff [2];
   logic               wr_ptr_ff;
   logic               rd_ptr_ff;
   logic [1:0]         count_ff;

   assign full      = (count_ff == 2'd2);
   assign empty     = (count_ff == 2'd0);
   assign pop_entry = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   `ASSERT_IMPLIES(a_no_overrun, clock, reset, push, !full, "push into a full queue")
   `ASSERT_IMPLIES(a_no_underrun, clock, reset, pop, !empty, "pop from an empty queue")
   `ASSERT_NEXT(a_push_fills, clock, reset, push && !pop, !empty, "pushed entry was lost")

endmodule

[hw/rtl/rau_front.sv]
// Front part: accepts requests, forms the cross products and classifies errors.
module rau_front #(
   parameter int WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   rau_req_if.sink            req_chan,
   output logic               push,
   output rau_pkg::entry_type push_entry,
   input  logic               full
);

   localparam logic signed [63:0] LIM_MAX = (64'sd1 <<< (WIDTH - 1)) - 64'sd1;
   localparam logic signed [63:0] LIM_MIN = -LIM_MAX - 64'sd1;

   typedef enum logic [2:0] {F_IDLE, F_MUL0, F_MUL1, F_MUL2, F_CHK} fstate_type;

   fstate_type         state_ff;
   rau_pkg::op_type    op_ff;
   logic signed [31:0] an_ff;
   logic signed [31:0] bn_ff;
   logic [30:0]        ad_ff;
   logic [30:0]        bd_ff;
   logic signed [63:0] p0_ff;
   logic signed [63:0] p1_ff;
   logic signed [63:0] p2_ff;

   logic signed [32:0] mul_x;
   logic signed [32:0] mul_y;
   logic signed [65:0] mul_p;
   logic signed [63:0] n_sum;
   rau_pkg::status_type chk_status;

   assign req_chan.ready = (state_ff == F_IDLE);

   // One shared multiplier, one product per cycle.
   always_comb begin
      case (state_ff)
         F_MUL0: begin
            mul_x = {an_ff[31], an_ff};
            mul_y = (op_ff == rau_pkg::OP_MUL) ? {bn_ff[31], bn_ff} : {2'b00, bd_ff};
         end
         F_MUL1: begin
            mul_x = {bn_ff[31], bn_ff};
            mul_y = {2'b00, ad_ff};
         end
         default: begin
            mul_x = {2'b00, ad_ff};
            mul_y = (op_ff == rau_pkg::OP_DIV) ? {bn_ff[31], bn_ff} : {2'b00, bd_ff};
         end
      endcase
      mul_p = mul_x * mul_y;
   end

   always_comb begin
      case (op_ff)
         rau_pkg::OP_ADD: n_sum = p0_ff + p1_ff;
         rau_pkg::OP_SUB: n_sum = p0_ff - p1_ff;
         default:         n_sum = p0_ff;
      endcase
      if (op_ff == rau_pkg::OP_DIV && bn_ff == 32'sd0) begin
         chk_status = rau_pkg::ST_DIVZ;
      end else if (n_sum > LIM_MAX || n_sum < LIM_MIN || p2_ff > LIM_MAX || p2_ff < LIM_MIN) begin
         chk_status = rau_pkg::ST_OVF;
      end else if (p2_ff == 64'sd0) begin
         chk_status = rau_pkg::ST_DIVZ;
      end else begin
         chk_status = rau_pkg::ST_OK;
      end
      push_entry.status = chk_status;
      push_entry.num    = n_sum[31:0];
      push_entry.den    = p2_ff[31:0];
   end

   assign push = (state_ff == F_CHK) && !full;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (req_chan.valid) begin
                  op_ff    <= rau_pkg::op_type'(req_chan.func);
                  an_ff    <= req_chan.a_num;
                  ad_ff    <= req_chan.a_den;
                  bn_ff    <= req_chan.b_num;
                  bd_ff    <= req_chan.b_den;
                  state_ff <= F_MUL0;
               end
            end
            F_MUL0: begin
               p0_ff    <= mul_p[63:0];
               state_ff <= F_MUL1;
            end
            F_MUL1: begin
               p1_ff    <= mul_p[63:0];
               state_ff <= F_MUL2;
            end
            F_MUL2: begin
               p2_ff    <= mul_p[63:0];
               state_ff <= F_CHK;
            end
            F_CHK: begin
               if (!full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

endmodule

[hw/rtl/rau_back.sv]
// Back part: binary GCD, two restoring dividers and the response register.
`include "assert_macros.svh"

module rau_back #(
   parameter int WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               empty,
   input  rau_pkg::entry_type pop_entry,
   output logic               pop,
   rau_rsp_if.source          rsp_chan
);

   localparam logic [32:0] MAG_LIM = 33'd1 << (WIDTH - 1);

   typedef enum logic [1:0] {B_IDLE, B_GCD, B_DIV, B_DONE} bstate_type;

   bstate_type          state_ff;
   rau_pkg::status_type status_ff;
   logic                neg_ff;
   logic [31:0]         nq_ff;
   logic [31:0]         dq_ff;
   logic [31:0]         u_ff;
   logic [31:0]         v_ff;
   logic [4:0]          k_ff;
   logic [31:0]         g_ff;
   logic [31:0]         rn_ff;
   logic [31:0]         rd_ff;
   logic [4:0]          cnt_ff;
   logic                rsp_valid_ff;
   logic signed [31:0]  res_num_ff;
   logic [30:0]         res_den_ff;
   rau_pkg::status_type status_out_ff;

   logic [32:0] tn;
   logic [32:0] td;
   logic        bn_q;
   logic        bd_q;
   logic [31:0] in_nmag;
   logic [31:0] in_dmag;
   logic        fits;
   logic        out_free;

   assign pop      = (state_ff == B_IDLE) && !empty;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   assign in_nmag = pop_entry.num[31] ? 32'(-pop_entry.num) : pop_entry.num;
   assign in_dmag = pop_entry.den[31] ? 32'(-pop_entry.den) : pop_entry.den;

   assign tn   = {rn_ff, nq_ff[31]};
   assign td   = {rd_ff, dq_ff[31]};
   assign bn_q = (tn >= {1'b0, g_ff});
   assign bd_q = (td >= {1'b0, g_ff});

   // A negative result may reach one step further than a positive one.
   assign fits = (neg_ff ? ({1'b0, nq_ff} <= MAG_LIM) : ({1'b0, nq_ff} < MAG_LIM))
                 && ({1'b0, dq_ff} < MAG_LIM);

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.res_num = res_num_ff;
   assign rsp_chan.res_den = res_den_ff;
   assign rsp_chan.status  = status_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // In the done state the register is either refilled or still stalled.
         if (rsp_valid_ff && rsp_chan.ready && state_ff != B_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_IDLE: begin
               if (!empty) begin
                  status_ff <= pop_entry.status;
                  neg_ff    <= pop_entry.num[31] ^ pop_entry.den[31];
                  u_ff      <= in_nmag;
                  v_ff      <= in_dmag;
                  nq_ff     <= in_nmag;
                  dq_ff     <= in_dmag;
                  k_ff      <= 5'd0;
                  state_ff  <= (pop_entry.status == rau_pkg::ST_OK) ? B_GCD : B_DONE;
               end
            end
            B_GCD: begin
               if (u_ff == 32'd0) begin
                  g_ff     <= v_ff << k_ff;
                  rn_ff    <= 32'd0;
                  rd_ff    <= 32'd0;
                  cnt_ff   <= 5'd0;
                  state_ff <= B_DIV;
               end else if (!u_ff[0] && !v_ff[0]) begin
                  u_ff <= u_ff >> 1;
                  v_ff <= v_ff >> 1;
                  k_ff <= k_ff + 5'd1;
               end else if (!u_ff[0]) begin
                  u_ff <= u_ff >> 1;
               end else if (!v_ff[0]) begin
                  v_ff <= v_ff >> 1;
               end else if (u_ff >= v_ff) begin
                  u_ff <= u_ff - v_ff;
               end else begin
                  v_ff <= v_ff - u_ff;
               end
            end
            B_DIV: begin
               rn_ff  <= bn_q ? 32'(tn - {1'b0, g_ff}) : tn[31:0];
               rd_ff  <= bd_q ? 32'(td - {1'b0, g_ff}) : td[31:0];
               nq_ff  <= {nq_ff[30:0], bn_q};
               dq_ff  <= {dq_ff[30:0], bd_q};
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd31) begin
                  state_ff <= B_DONE;
               end
            end
            B_DONE: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  if (status_ff == rau_pkg::ST_OK && fits) begin
                     res_num_ff    <= neg_ff ? -$signed(nq_ff) : $signed(nq_ff);
                     res_den_ff    <= dq_ff[30:0];
                     status_out_ff <= rau_pkg::ST_OK;
                  end else begin
                     res_num_ff    <= 32'sd0;
                     res_den_ff    <= 31'd0;
                     status_out_ff <= (status_ff == rau_pkg::ST_OK) ? rau_pkg::ST_OVF
                                                                   : status_ff;
                  end
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   `ASSERT_IMPLIES(a_ok_den, clock, reset,
      rsp_valid_ff && status_out_ff == rau_pkg::ST_OK, res_den_ff != 31'd0,
      "good result with zero denominator")
   `ASSERT_IMPLIES(a_err_zero, clock, reset,
      rsp_valid_ff && status_out_ff != rau_pkg::ST_OK,
      res_num_ff == 32'sd0 && res_den_ff == 31'd0, "error result not zero")
   `ASSERT_NEXT(a_pop_busy, clock, reset, pop, state_ff != B_IDLE,
      "popped entry not taken up")
   `ASSERT_IMPLIES(a_gcd_den, clock, reset, state_ff == B_GCD, v_ff != 32'd0,
      "GCD reached a zero operand")

endmodule
